// File: src/histogram_valley_threshold_binarizer_macros.svh
// Assertion helpers shared by the binarizer RTL.
`ifndef HISTOGRAM_VALLEY_THRESHOLD_BINARIZER_MACROS_SVH
`define HISTOGRAM_VALLEY_THRESHOLD_BINARIZER_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define HVTB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define HVTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/hvtb_pkg.sv
package hvtb_pkg;

   // Pixel and histogram geometry
   localparam int CHAN_W    = 8;
   localparam int BIN_COUNT = 256;
   localparam int BIN_AW    = 8;
   localparam int BIN_W     = 21;
   localparam logic [BIN_W-1:0] BIN_MAX = '1;
   localparam int COUNT_W   = 8;

   // Divide-by-three: floor(sum * 683 / 2048) is exact for sums up to 765
   localparam int SUM_W     = 10;
   localparam int RECIP_W   = 10;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] BR_RECIP = 10'd683;
   localparam int BR_SHIFT  = 11;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_FINISH   = 2'd1,
      OP_CLASSIFY = 2'd2
   } op_type;

   typedef enum logic {
      KIND_THRESHOLD = 1'b0,
      KIND_PIXEL     = 1'b1
   } kind_type;

   typedef struct packed {
      op_type             op;
      logic [CHAN_W-1:0]  bright;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/hvtb_front.sv
module hvtb_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_op,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  hvtb_pkg::queue_status_type q_status,
   output logic                     push,
   output hvtb_pkg::item_type       push_item
);
   import hvtb_pkg::*;

   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   logic              op_known;

   // Form brightness as floor((r+g+b)/3) by reciprocal multiply
   assign sum  = SUM_W'(req_red) + SUM_W'(req_green) + SUM_W'(req_blue);
   assign prod = PROD_W'(sum) * PROD_W'(BR_RECIP);

   // Drop the unused op code here so the back never sees it
   assign op_known = (req_op == OP_ADD) || (req_op == OP_FINISH) ||
                     (req_op == OP_CLASSIFY);

   assign req_ready        = !q_status.full;
   assign push             = req_valid && req_ready && op_known;
   assign push_item.op     = op_type'(req_op);
   assign push_item.bright = prod[BR_SHIFT +: CHAN_W];

endmodule

// File: src/hvtb_queue.sv
module hvtb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hvtb_pkg::item_type         push_item,
   input  logic                       pop,
   output hvtb_pkg::item_type         pop_item,
   output hvtb_pkg::queue_status_type q_status
);
   import hvtb_pkg::*;

   item_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries until popped
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item       = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

// File: src/hvtb_back.sv
module hvtb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hvtb_pkg::item_type         head,
   input  hvtb_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [7:0]                 rsp_threshold,
   output logic                       rsp_pixel_on,
   output logic [7:0]                 rsp_valley_count
);
   import hvtb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_CALC
   } state_type;

   // Histogram store: bins plus one valid bit each, so a clear is immediate
   logic [BIN_W-1:0]   hist_mem [BIN_COUNT];
   logic [BIN_COUNT-1:0] hv_ff;
   logic [BIN_W-1:0]   hist_rd_ff;
   logic               hv_rd_ff;
   logic [BIN_AW-1:0]  rd_addr;

   // Ascending list of valley indices from the last scan
   logic [BIN_AW-1:0]  min_mem [BIN_COUNT];
   logic [BIN_AW-1:0]  min_hi_ff, min_lo_ff;
   logic [COUNT_W-1:0] mid;

   state_type          state_ff, state_in;
   logic [BIN_AW-1:0]  scan_cnt_ff, scan_cnt_in;
   logic               sd_valid_ff, sd_valid_in;
   logic [BIN_AW-1:0]  sd_idx_ff, sd_idx_in;
   logic [BIN_W-1:0]   w1_ff, w1_in, w2_ff, w2_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic               inc_valid_ff, inc_valid_in;
   logic [BIN_AW-1:0]  inc_addr_ff, inc_addr_in;
   logic               wr_last_ff, wr_last_in;
   logic [BIN_AW-1:0]  wr_last_addr_ff, wr_last_addr_in;
   logic [BIN_W-1:0]   wr_last_data_ff, wr_last_data_in;
   logic [CHAN_W-1:0]  thr_ff, thr_in;
   logic [COUNT_W-1:0] vc_ff, vc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [CHAN_W-1:0]  rsp_thr_ff, rsp_thr_in;
   logic               rsp_on_ff, rsp_on_in;
   logic [COUNT_W-1:0] rsp_vc_ff, rsp_vc_in;

   logic               out_free;
   logic [BIN_W-1:0]   old_bin, new_bin, scan_val;
   logic               is_min, min_we, hist_clear;
   logic [CHAN_W:0]    mid_sum;
   logic [CHAN_W-1:0]  thr_calc;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Take the head item only when the stage it needs is free
   assign pop = (state_ff == ST_IDLE) && !q_status.empty &&
                ((head.op != OP_CLASSIFY) || out_free);

   assign rd_addr = (state_ff == ST_SCAN) ? scan_cnt_ff : head.bright;

   // Increment stage: forward the previous cycle's write on an address match
   always_comb begin
      if (wr_last_ff && (wr_last_addr_ff == inc_addr_ff)) begin
         old_bin = wr_last_data_ff;
      end else begin
         old_bin = hv_rd_ff ? hist_rd_ff : '0;
      end
      new_bin = (old_bin == BIN_MAX) ? old_bin : old_bin + 1'b1;
   end

   // Scan window: a bin is a valley when both neighbors are not smaller
   assign scan_val = hv_rd_ff ? hist_rd_ff : '0;
   assign is_min   = (w2_ff >= w1_ff) && (w1_ff <= scan_val);
   assign min_we   = sd_valid_ff && (sd_idx_ff >= BIN_AW'(2)) && is_min;
   assign mid      = n_ff >> 1;

   // Median of the valley list
   assign mid_sum = {1'b0, min_lo_ff} + {1'b0, min_hi_ff};
   always_comb begin
      if (n_ff == '0) begin
         thr_calc = '0;
      end else if (n_ff[0]) begin
         thr_calc = min_hi_ff;
      end else begin
         thr_calc = mid_sum[CHAN_W:1];
      end
   end

   assign hist_clear = (state_ff == ST_CALC) && out_free;

   // Next-state and result logic
   always_comb begin
      state_in        = state_ff;
      scan_cnt_in     = scan_cnt_ff;
      sd_valid_in     = 1'b0;
      sd_idx_in       = scan_cnt_ff;
      w1_in           = w1_ff;
      w2_in           = w2_ff;
      n_in            = n_ff;
      inc_valid_in    = pop && (head.op == OP_ADD);
      inc_addr_in     = head.bright;
      wr_last_in      = inc_valid_ff;
      wr_last_addr_in = inc_addr_ff;
      wr_last_data_in = new_bin;
      thr_in          = thr_ff;
      vc_in           = vc_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_thr_in      = rsp_thr_ff;
      rsp_on_in       = rsp_on_ff;
      rsp_vc_in       = rsp_vc_ff;

      if (sd_valid_ff) begin
         w1_in = scan_val;
         w2_in = w1_ff;
         if (min_we) begin
            n_in = n_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop && (head.op == OP_FINISH)) begin
               state_in    = ST_SCAN;
               scan_cnt_in = '0;
               n_in        = '0;
            end
            if (pop && (head.op == OP_CLASSIFY)) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PIXEL;
               rsp_thr_in   = thr_ff;
               rsp_on_in    = (head.bright > thr_ff);
               rsp_vc_in    = vc_ff;
            end
         end
         ST_SCAN: begin
            sd_valid_in = 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == BIN_AW'(BIN_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (out_free) begin
               thr_in       = thr_calc;
               vc_in        = n_ff;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_THRESHOLD;
               rsp_thr_in   = thr_calc;
               rsp_on_in    = 1'b0;
               rsp_vc_in    = n_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         sd_valid_ff  <= 1'b0;
         n_ff         <= '0;
         inc_valid_ff <= 1'b0;
         wr_last_ff   <= 1'b0;
         thr_ff       <= '0;
         vc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         sd_valid_ff  <= sd_valid_in;
         n_ff         <= n_in;
         inc_valid_ff <= inc_valid_in;
         wr_last_ff   <= wr_last_in;
         thr_ff       <= thr_in;
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sd_idx_ff       <= sd_idx_in;
      w1_ff           <= w1_in;
      w2_ff           <= w2_in;
      inc_addr_ff     <= inc_addr_in;
      wr_last_addr_ff <= wr_last_addr_in;
      wr_last_data_ff <= wr_last_data_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_thr_ff      <= rsp_thr_in;
      rsp_on_ff       <= rsp_on_in;
      rsp_vc_ff       <= rsp_vc_in;
   end

   // Histogram bins: one write, one registered read
   always_ff @(posedge clock) begin
      if (inc_valid_ff) begin
         hist_mem[inc_addr_ff] <= new_bin;
      end
      hist_rd_ff <= hist_mem[rd_addr];
   end

   // Bin valid bits: clear all at reset and at the end of a frame
   always_ff @(posedge clock) begin
      if (reset || hist_clear) begin
         hv_ff <= '0;
      end else if (inc_valid_ff) begin
         hv_ff[inc_addr_ff] <= 1'b1;
      end
      hv_rd_ff <= hv_ff[rd_addr];
   end

   // Valley list: append during the scan, read the middle pair after it
   always_ff @(posedge clock) begin
      if (min_we) begin
         min_mem[n_ff] <= sd_idx_ff - 1'b1;
      end
      min_hi_ff <= min_mem[mid];
      min_lo_ff <= min_mem[mid - 1'b1];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_threshold    = rsp_thr_ff;
   assign rsp_pixel_on     = rsp_on_ff;
   assign rsp_valley_count = rsp_vc_ff;

endmodule

// File: src/histogram_valley_threshold_binarizer.sv
// Two-pass RGB binarizer. Op 0 beats add floor((r+g+b)/3) to a 256-bin saturating histogram and
// op 2 beats classify a pixel against the current threshold; both are taken at one per cycle
// while the queue has room, the back end is idle and, for op 2, the output is free, and are
// answered in order, op 0 giving no result. An op 1 beat finishes a frame: the back end walks
// all 256 bins through the histogram memory's single read port, one bin per cycle, then closes
// the last window and picks the median valley in its drain, fetch and calc states. A 4-entry
// queue keeps accepting beats during that scan until it fills. Op 3 is dropped at the input.
// Reset clears the histogram at once through per-bin valid bits; there is no clearing pass.
`include "histogram_valley_threshold_binarizer_macros.svh"

module histogram_valley_threshold_binarizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_threshold,
   output logic       rsp_pixel_on,
   output logic [7:0] rsp_valley_count
);
   import hvtb_pkg::*;

   queue_status_type q_status;
   item_type         push_item;
   item_type         head;
   logic             push;
   logic             pop;
   logic             thr_beat;
   logic             vc_ok;

   hvtb_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   hvtb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (head),
      .q_status  (q_status)
   );

   hvtb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_threshold    (rsp_threshold),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_valley_count (rsp_valley_count)
   );

   assign thr_beat = rsp_valid && (rsp_kind == KIND_THRESHOLD);
   assign vc_ok    = (rsp_valley_count != 8'd255);

   // A pushed beat is still queued on the next cycle
   `HVTB_ASSERT_NEXT(a_push_lands, clock, reset, push, !q_status.empty, "pushed beat lost")
   // The back end never pops an empty queue
   `HVTB_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, !q_status.empty, "pop from empty queue")
   // A threshold result never reports a white pixel
   `HVTB_ASSERT_SAME(a_thr_off, clock, reset, thr_beat, !rsp_pixel_on, "threshold with pixel_on")
   // At most 254 valleys fit between the edge bins
   `HVTB_ASSERT_SAME(a_count_range, clock, reset, rsp_valid, vc_ok, "valley count out of range")

endmodule
